// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the ring store RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is held.
`define OSR_ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ring store assertion failed");

// A condition that must never be seen at a clock edge.
`define OSR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `OSR_ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

// ----- rtl/osr_pkg.sv -----
// ---------------------------------------------------------------------------
// osr_pkg
// Types and constants shared by the overwriting sample ring modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package osr_pkg;

  localparam int unsigned DEPTH_DEF        = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  localparam int unsigned NUM_AXES    = 6;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned AMOUNT_W    = 7;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned SAMPLE_LSB  = AMOUNT_W;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned IN_TUSER_W  = MODE_W;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH       = 3'd0,
    MODE_READ_AT    = 3'd1,
    MODE_OLDEST_RUN = 3'd2,
    MODE_NEWEST_RUN = 3'd3,
    MODE_CLEAR      = 3'd4
  } osr_mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STAT,
    S_EMIT
  } osr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic start_rd;  // first store read of a read-at or a run
    logic next_rd;   // following store read of a run
    logic emit_stat; // load a status-only result
    logic emit_data; // load a result carrying the read sample
  } osr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read; // current input item reads the store
    logic slot_free;  // output register can take a result
    logic run_last;   // the sample being emitted is the last of the item
  } osr_sts_t;

endpackage

// ----- rtl/osr_datapath.sv -----
// ---------------------------------------------------------------------------
// osr_datapath
// Sample store, ring pointers, read address sequencing and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module osr_datapath #(
  parameter int unsigned DEPTH        = osr_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = osr_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  osr_pkg::osr_cmd_t                cmd_i,
  output osr_pkg::osr_sts_t                sts_o,
  input  logic [osr_pkg::IN_TUSER_W-1:0]   in_user_i,
  input  logic [osr_pkg::IN_TDATA_W-1:0]   in_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [osr_pkg::OUT_TDATA_W-1:0]  out_data_o,
  output logic [osr_pkg::OUT_TUSER_W-1:0]  out_user_o,
  output logic                             out_last_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned EW = osr_pkg::NUM_AXES * SW;
  localparam int unsigned FW = osr_pkg::FIELD_W;
  localparam int unsigned AW = osr_pkg::AMOUNT_W;
  localparam int unsigned DW = osr_pkg::NUM_AXES * FW;
  localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  function automatic logic [PW-1:0] wrap_idx(input logic [PW:0] v);
    logic [PW:0] r;
    r = (v >= DEPTH_P) ? v - DEPTH_P : v;
    return r[PW-1:0];
  endfunction

  osr_pkg::osr_mode_e mode;
  logic [AW-1:0]      amount;
  logic [AW-1:0]      count_ext;
  logic [PW:0]        amt_p;
  logic [EW-1:0]      wr_word;
  logic [DW-1:0]      rd_fields;

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_data_q;

  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] addr_q;
  logic [CW-1:0] rem_q;
  logic          stat_q;

  logic          in_status;
  logic          needs_read;
  logic [PW-1:0] start_addr;
  logic [CW-1:0] rem_start;
  logic [PW-1:0] rd_addr;
  logic          rd_en;
  logic          slot_free;
  logic          load;

  logic                            out_valid_q;
  logic [osr_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic [osr_pkg::OUT_TUSER_W-1:0] out_user_q;
  logic                            out_last_q;

  assign mode      = osr_pkg::osr_mode_e'(in_user_i);
  assign amount    = in_data_i[AW-1:0];
  assign count_ext = AW'(count_q);
  assign amt_p     = amount[PW:0];

  // Fields are sign extended or cut down to the stored code width, and back.
  for (genvar a = 0; a < osr_pkg::NUM_AXES; a++) begin : g_axis
    logic signed [FW-1:0] in_f;
    logic signed [31:0]   in_ext;
    logic signed [SW-1:0] rd_code;
    logic signed [31:0]   rd_ext;
    assign in_f   = in_data_i[osr_pkg::SAMPLE_LSB + a * FW +: FW];
    assign in_ext = 32'(in_f);
    assign wr_word[a * SW +: SW] = in_ext[SW-1:0];
    assign rd_code = rd_data_q[a * SW +: SW];
    assign rd_ext  = 32'(rd_code);
    assign rd_fields[a * FW +: FW] = rd_ext[FW-1:0];
  end

  always_comb begin
    in_status  = 1'b0;
    needs_read = 1'b0;
    start_addr = oldest_q;
    rem_start  = amount[CW-1:0];
    unique case (mode)
      osr_pkg::MODE_READ_AT: begin
        in_status  = (amount >= count_ext);
        needs_read = (amount < count_ext);
        start_addr = wrap_idx({1'b0, oldest_q} + amt_p);
        rem_start  = CW'(1);
      end
      osr_pkg::MODE_OLDEST_RUN: begin
        in_status  = (amount > count_ext);
        needs_read = (amount <= count_ext) && (amount != '0);
        start_addr = oldest_q;
      end
      osr_pkg::MODE_NEWEST_RUN: begin
        in_status  = (amount > count_ext);
        needs_read = (amount <= count_ext) && (amount != '0);
        start_addr = wrap_idx({1'b0, wp_q} + DEPTH_P - amt_p);
      end
      default: begin
        in_status  = 1'b0;
        needs_read = 1'b0;
      end
    endcase
  end

  // Pointer update; a push into a full ring drops the oldest sample.
  always_comb begin
    wp_d     = wp_q;
    oldest_d = oldest_q;
    count_d  = count_q;
    if (cmd_i.accept && mode == osr_pkg::MODE_PUSH) begin
      wp_d = wrap_idx({1'b0, wp_q} + (PW + 1)'(1));
      if (count_q < DEPTH_C) begin
        count_d = count_q + CW'(1);
      end else begin
        oldest_d = wrap_idx({1'b0, oldest_q} + (PW + 1)'(1));
      end
    end else if (cmd_i.accept && mode == osr_pkg::MODE_CLEAR) begin
      wp_d     = '0;
      oldest_d = '0;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      oldest_q <= '0;
      count_q  <= '0;
    end else begin
      wp_q     <= wp_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
    end
  end

  assign rd_addr = cmd_i.start_rd ? start_addr : addr_q;
  assign rd_en   = cmd_i.start_rd | cmd_i.next_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && mode == osr_pkg::MODE_PUSH) begin
      mem_q[wp_q] <= wr_word;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      rem_q  <= '0;
    end else if (rd_en) begin
      addr_q <= wrap_idx({1'b0, rd_addr} + (PW + 1)'(1));
      rem_q  <= cmd_i.start_rd ? rem_start : rem_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      stat_q <= in_status;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = cmd_i.emit_stat | cmd_i.emit_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result fields from the lowest bit: six samples, fill count, full flag.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q[DW-1:0] <= cmd_i.emit_data ? rd_fields : '0;
      out_data_q[DW +: osr_pkg::COUNT_W] <= osr_pkg::COUNT_W'(count_d);
      out_data_q[DW + osr_pkg::COUNT_W]  <= (count_d == DEPTH_C);
      out_user_q[0] <= cmd_i.emit_data ? 1'b0 : (cmd_i.accept ? in_status : stat_q);
      out_user_q[1] <= cmd_i.emit_data;
      out_last_q    <= cmd_i.emit_data ? (rem_q == CW'(1)) : 1'b1;
    end
  end

  assign sts_o.needs_read = needs_read;
  assign sts_o.slot_free  = slot_free;
  assign sts_o.run_last   = (rem_q == CW'(1));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  `OSR_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > DEPTH_C)
  `OSR_ASSERT_PROP(a_ptr_meet, clk_i, rst_ni, (count_q == DEPTH_C || count_q == '0) |-> (oldest_q == wp_q))

endmodule

// ----- rtl/osr_ctrl.sv -----
// ---------------------------------------------------------------------------
// osr_ctrl
// Controller that takes items and sequences status and sample results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module osr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  osr_pkg::osr_sts_t sts_i,
  output osr_pkg::osr_cmd_t cmd_o
);

  osr_pkg::osr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= osr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      osr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.needs_read) begin
            cmd_o.start_rd = 1'b1;
            state_d        = osr_pkg::S_EMIT;
          end else if (sts_i.slot_free) begin
            // A status-only result goes straight out when the register is free.
            cmd_o.emit_stat = 1'b1;
          end else begin
            state_d = osr_pkg::S_STAT;
          end
        end
      end
      osr_pkg::S_STAT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_stat = 1'b1;
          state_d         = osr_pkg::S_IDLE;
        end
      end
      osr_pkg::S_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_data = 1'b1;
          // The next read overlaps the emit so that a run streams each cycle while the result register stays free.
          if (sts_i.run_last) begin
            state_d = osr_pkg::S_IDLE;
          end else begin
            cmd_o.next_rd = 1'b1;
          end
        end
      end
      default: begin
        state_d = osr_pkg::S_IDLE;
      end
    endcase
  end

  `OSR_ASSERT_PROP(a_start_to_emit, clk_i, rst_ni, cmd_o.start_rd |=> (state_q == osr_pkg::S_EMIT))
  `OSR_ASSERT_NEVER(a_read_past_run, clk_i, rst_ni, cmd_o.next_rd && sts_i.run_last)

endmodule

// ----- rtl/overwriting_sample_ring.sv -----
// A push, clear or status-only item is loaded into the output register at accept if it is free.
// A read-at or run reads its first sample into the store read register, then the output register.
// Throughput: status-only items one per cycle while the output is free; a run holds the input
// until its last sample is emitted, set by the single registered read port of the sample store.
// Reset clears pointers, fill count and control at once; store contents are left as they are.
// ---------------------------------------------------------------------------
// overwriting_sample_ring
// Ring store of six-axis motion samples that overwrites the oldest when full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module overwriting_sample_ring #(
  parameter int unsigned DEPTH        = osr_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = osr_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // amount, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, zero pad
  input  logic [osr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // mode
  input  logic [osr_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_acc_x, out_acc_y, out_acc_z, out_gyro_x, out_gyro_y, out_gyro_z, fill_count, full_res
  output logic [osr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status, data_valid
  output logic [osr_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  osr_pkg::osr_cmd_t cmd;
  osr_pkg::osr_sts_t sts;

  osr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  osr_datapath #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_user_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
